// ===== design/cksum_pkg.sv =====
// Shared types, constants and the CRC byte update for the cksum block.
`default_nettype none

package cksum_pkg;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;      // an input transfer completes this cycle
    logic close;     // that transfer ends the message
    logic fold_len;  // fold the next length byte into the CRC
    logic emit;      // load the result register and clear the message state
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic len_zero;  // no length bytes remain to be folded
    logic out_free;  // the result register can take a new result
  } status_t;

  // One byte of a non-reflected CRC-32, MSB first.
  function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                            input logic [7:0] byte_in);
    logic [31:0] c;
    c = crc_in ^ {byte_in, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[31] ? ({c[30:0], 1'b0} ^ CRC_POLY) : {c[30:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== design/cksum_ctrl.sv =====
// Controller: sequences message bytes, the length trailer and the result hand-off.
`default_nettype none

module cksum_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_valid,
  input  wire logic               s_last,
  output logic                    s_ready,
  input  wire cksum_pkg::status_t st,
  output cksum_pkg::cmd_t         cmd
);

  typedef enum logic {
    ST_DATA,
    ST_TRAIL
  } state_t;

  state_t state;

  always_comb begin
    cmd          = '0;
    cmd.take     = s_ready && s_valid;
    cmd.close    = s_ready && s_valid && s_last;
    unique case (state)
      ST_DATA: begin
      end
      ST_TRAIL: begin
        if (!st.len_zero) begin
          cmd.fold_len = 1'b1;
        end else if (st.out_free) begin
          cmd.emit = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // The input stays closed during reset and opens at a clock edge with reset low.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_DATA;
      s_ready <= 1'b0;
    end else begin
      unique case (state)
        ST_DATA: begin
          if (cmd.close) begin
            state   <= ST_TRAIL;
            s_ready <= 1'b0;
          end else begin
            s_ready <= 1'b1;
          end
        end
        ST_TRAIL: begin
          if (cmd.emit) begin
            state   <= ST_DATA;
            s_ready <= 1'b1;
          end
        end
        default: begin
          state   <= ST_DATA;
          s_ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/cksum_dpath.sv =====
// Datapath: running CRC, saturating byte counter, length shifter and result register.
`default_nettype none

module cksum_dpath #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire cksum_pkg::cmd_t  cmd,
  output cksum_pkg::status_t    st,
  input  wire logic [7:0]       data_byte,
  input  wire logic             has_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           checksum,
  output logic [31:0]           message_length,
  output logic                  length_overflow
);

  localparam int CNT_W = (LENGTH_BITS > 32) ? 32 : LENGTH_BITS;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [31:0]      crc;
  logic [CNT_W-1:0] cnt;
  logic             sat;
  logic [CNT_W-1:0] len_sh;
  logic [CNT_W-1:0] cnt_next;
  logic             sat_next;
  logic             at_max;

  assign at_max   = (cnt == CNT_MAX);
  assign cnt_next = (has_byte && !at_max) ? cnt + CNT_W'(1) : cnt;
  assign sat_next = sat | (has_byte && at_max);

  assign st.len_zero = (len_sh == '0);
  assign st.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
      cnt <= '0;
      sat <= 1'b0;
    end else if (cmd.emit) begin
      crc <= '0;
      cnt <= '0;
      sat <= 1'b0;
    end else if (cmd.fold_len) begin
      crc <= cksum_pkg::fold_byte(crc, len_sh[7:0]);
    end else if (cmd.take) begin
      if (has_byte) begin
        crc <= cksum_pkg::fold_byte(crc, data_byte);
      end
      cnt <= cnt_next;
      sat <= sat_next;
    end
  end

  // The length goes out least significant byte first; it is done once only zero bytes remain.
  always_ff @(posedge clk) begin
    if (rst) begin
      len_sh <= '0;
    end else if (cmd.close) begin
      len_sh <= cnt_next;
    end else if (cmd.fold_len) begin
      len_sh <= len_sh >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      checksum        <= ~crc;
      message_length  <= 32'(cnt);
      length_overflow <= sat;
    end
  end

endmodule

`default_nettype wire

// ===== design/cksum_crc32_with_length_top.sv =====
// Top level of the cksum-style CRC-32 with appended length trailer.
//
//  Channel  | Direction | Contents
//  ---------+-----------+-------------------------------------------------------
//  s_axis   | in        | tdata: data_byte; tuser: has_byte; tlast: end_of_message
//  m_axis   | out       | tdata: checksum, message_length; tuser: length_overflow
//
// Message bytes are taken one per cycle while the input is ready; the counter and the CRC byte update set that pace.
// After the closing transfer the input is held off while the n length bytes, n (0 to 4),
// go one per cycle through the same CRC update and the result is then emitted.
// The result sits in an output register, so the next message starts while it waits.
// If that register is still full after the trailer, the block waits until it is taken.
// Reset is synchronous and clears the message state and the output valid; the input
// goes ready at a clock edge with reset low.
`default_nettype none

module cksum_crc32_with_length_top #(
  parameter int LENGTH_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] has_byte
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // [31:0] checksum, [63:32] message_length
  output logic [0:0]       m_axis_tuser    // [0] length_overflow
);

  localparam int CNT_W = (LENGTH_BITS > 32) ? 32 : LENGTH_BITS;

  cksum_pkg::cmd_t    cmd;
  cksum_pkg::status_t st;
  logic [31:0]        checksum;
  logic [31:0]        message_length;
  logic               length_overflow;

  cksum_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_last  (s_axis_tlast),
    .s_ready (s_axis_tready),
    .st      (st),
    .cmd     (cmd)
  );

  cksum_dpath #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .data_byte       (s_axis_tdata),
    .has_byte        (s_axis_tuser[0]),
    .out_valid       (m_axis_tvalid),
    .out_ready       (m_axis_tready),
    .checksum        (checksum),
    .message_length  (message_length),
    .length_overflow (length_overflow)
  );

  assign m_axis_tdata = {message_length, checksum};
  assign m_axis_tuser = length_overflow;

  // The closing transfer always blocks the input for at least the emit cycle.
  a_close_blocks: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
    else $error("input still ready after closing transfer");

  // A reported length never exceeds the counter range.
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ((m_axis_tdata[63:32] >> CNT_W) == 32'd0))
    else $error("message length beyond counter range");

  // An overflow flag comes only with a length held at its maximum.
  a_sat_len: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata[63:32] == 32'({CNT_W{1'b1}})))
    else $error("overflow flagged with a length below the maximum");

  // A new result is only loaded once the previous one has been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
    else $error("pending result overwritten");

endmodule

`default_nettype wire
